>>> rtl/atcr_pkg.sv
// shared constants and control types for the at command receiver
package atcr_pkg;

    localparam int MAX_COMMAND_CHARS = 15;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_A_UP  = 8'h41;
    localparam logic [7:0] CHAR_A_LO  = 8'h61;
    localparam logic [7:0] CHAR_T_UP  = 8'h54;
    localparam logic [7:0] CHAR_T_LO  = 8'h74;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_DONE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear_len;
        logic store_byte;
        logic start_emit;
        logic repeat_req;
        logic load_out;
    } atcr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_done;
        logic is_cr;
        logic is_lf;
        logic is_a;
        logic is_t;
        logic is_slash;
        logic len_zero;
        logic at_last;
        logic out_free;
    } atcr_status_t;

endpackage

>>> rtl/atcr_if.sv
// valid/ready channel interfaces for received bytes and command output
interface atcr_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface atcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd_byte;
    logic       cmd_empty;
    logic       is_repeat;
    logic       last;

    modport source (output valid, output cmd_byte, output cmd_empty, output is_repeat,
                    output last, input ready);
    modport sink (input valid, input cmd_byte, input cmd_empty, input is_repeat,
                  input last, output ready);
endinterface

>>> rtl/atcr_ctrl.sv
// parser and emission state machine of the at command receiver
module atcr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  atcr_pkg::atcr_status_t sts,
    output atcr_pkg::atcr_cmd_t    cmd
);
    import atcr_pkg::*;

    typedef enum logic [5:0] {
        S_WAIT_CR  = 6'b000001,
        S_AFTER_CR = 6'b000010,
        S_AFTER_A  = 6'b000100,
        S_COLLECT  = 6'b001000,
        S_EMIT     = 6'b010000,
        S_BUSY     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   acc;
    logic   byte_acc;

    assign in_ready = (state_reg != S_EMIT);
    assign acc      = in_valid & in_ready;
    assign byte_acc = acc & ~sts.op_done;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_WAIT_CR:
            begin
                if (byte_acc)
                begin
                    state_next = sts.is_cr ? S_AFTER_CR : S_WAIT_CR;
                end
            end
            S_AFTER_CR:
            begin
                if (byte_acc)
                begin
                    if (sts.is_a)
                    begin
                        state_next = S_AFTER_A;
                    end
                    else if (!sts.is_lf)
                    begin
                        state_next = S_WAIT_CR;
                    end
                end
            end
            S_AFTER_A:
            begin
                if (byte_acc)
                begin
                    if (sts.is_t)
                    begin
                        state_next    = S_COLLECT;
                        cmd.clear_len = 1'b1;
                    end
                    else if (sts.is_slash)
                    begin
                        state_next     = S_EMIT;
                        cmd.start_emit = 1'b1;
                        cmd.repeat_req = 1'b1;
                    end
                    else
                    begin
                        state_next = S_WAIT_CR;
                    end
                end
            end
            S_COLLECT:
            begin
                if (byte_acc)
                begin
                    if (sts.is_cr)
                    begin
                        state_next     = S_EMIT;
                        cmd.start_emit = 1'b1;
                    end
                    else
                    begin
                        cmd.store_byte = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.len_zero || sts.at_last)
                    begin
                        state_next = S_BUSY;
                    end
                end
            end
            S_BUSY:
            begin
                // bytes are swallowed until the consumer reports done
                if (acc && sts.op_done)
                begin
                    state_next = S_AFTER_CR;
                end
            end
            default:
            begin
                state_next = S_WAIT_CR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WAIT_CR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/atcr_dp.sv
// character decode, command store, read sequencing and output register
module atcr_dp #(
    parameter int MAX_CHARS = atcr_pkg::MAX_COMMAND_CHARS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   opcode,
    input  logic [7:0]             rx_byte,
    input  atcr_pkg::atcr_cmd_t    cmd,
    output atcr_pkg::atcr_status_t sts,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [7:0]             out_cmd_byte,
    output logic                   out_cmd_empty,
    output logic                   out_is_repeat,
    output logic                   out_last
);
    import atcr_pkg::*;

    localparam int LW = $clog2(MAX_CHARS + 1);
    localparam int IW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

    logic [7:0]    mem [MAX_CHARS];
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          rep_reg;
    logic          rep_next;
    logic [7:0]    rd_data_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    byte_reg;
    logic          empty_reg;
    logic          repeat_reg;
    logic          last_reg;
    logic          len_full;
    logic          store_en;

    assign len_full = (len_reg >= LW'(MAX_CHARS));
    assign store_en = cmd.store_byte & ~len_full;

    assign sts.op_done  = (opcode == OP_DONE);
    assign sts.is_cr    = (rx_byte == CHAR_CR);
    assign sts.is_lf    = (rx_byte == CHAR_LF);
    assign sts.is_a     = (rx_byte == CHAR_A_UP) || (rx_byte == CHAR_A_LO);
    assign sts.is_t     = (rx_byte == CHAR_T_UP) || (rx_byte == CHAR_T_LO);
    assign sts.is_slash = (rx_byte == CHAR_SLASH);
    assign sts.len_zero = (len_reg == '0);
    assign sts.at_last  = ((LW'(idx_reg) + LW'(1)) == len_reg);
    assign sts.out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        len_next = len_reg;
        if (cmd.clear_len)
        begin
            len_next = '0;
        end
        else if (store_en)
        begin
            len_next = len_reg + LW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start_emit)
        begin
            idx_next = '0;
        end
        else if (cmd.load_out && !sts.at_last && !sts.len_zero)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    assign rep_next       = cmd.start_emit ? cmd.repeat_req : rep_reg;
    assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            idx_reg       <= '0;
            rep_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // store write and registered read at the next emission index
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[len_reg[IW-1:0]] <= rx_byte;
        end
        rd_data_reg <= mem[idx_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            byte_reg   <= sts.len_zero ? 8'h00 : rd_data_reg;
            empty_reg  <= sts.len_zero;
            repeat_reg <= rep_reg;
            last_reg   <= sts.len_zero | sts.at_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_cmd_byte  = byte_reg;
    assign out_cmd_empty = empty_reg;
    assign out_is_repeat = repeat_reg;
    assign out_last      = last_reg;

endmodule

>>> rtl/at_command_receiver_top.sv
// top level of the at command receiver
//
//  channel | dir | payload                                | meaning
//  rx      | in  | opcode, rx_byte                        | serial byte or done request
//  cmd     | out | cmd_byte, cmd_empty, is_repeat, last   | one command character
//
// a finished command is sent at one character per cycle from the store read
// port while the output is not stalled; the first character is read ahead
// the rx side is held off only while characters are being read out
// downstream stalls hold the output register and the read index in place
// reset clears the parser, length and output valid; the store is not cleared
module at_command_receiver_top #(
    parameter int MAX_CHARS = atcr_pkg::MAX_COMMAND_CHARS
) (
    input  logic              clk,
    input  logic              rst_n,
    atcr_in_if.sink           rx,
    atcr_out_if.source        cmd
);
    import atcr_pkg::*;

    atcr_cmd_t    ctl_cmd;
    atcr_status_t ctl_sts;
    logic         rx_ready;

    // parser: tracks cr, lf, a, t or slash and sequences the readout
    atcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx_ready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    // datapath: character decode, command store and output register
    atcr_dp #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (rx.opcode),
        .rx_byte       (rx.rx_byte),
        .cmd           (ctl_cmd),
        .sts           (ctl_sts),
        .out_ready     (cmd.ready),
        .out_valid     (cmd.valid),
        .out_cmd_byte  (cmd.cmd_byte),
        .out_cmd_empty (cmd.cmd_empty),
        .out_is_repeat (cmd.is_repeat),
        .out_last      (cmd.last)
    );

    assign rx.ready = rx_ready;

`ifndef SYNTHESIS
    // while a command is only partly sent, no rx request may be taken
    a_no_rx_mid_command: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && !cmd.last) |-> !rx.ready)
        else $error("rx request taken in the middle of a command");

    // the empty item stands alone and carries a zero character
    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.cmd_empty) |-> (cmd.last && cmd.cmd_byte == 8'h00))
        else $error("empty command item malformed");

    // a new output request only appears when the readout is running
    a_out_from_readout: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.valid) |-> $past(!rx_ready))
        else $error("output request without readout");
`endif

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the at command receiver top level
import atcr_pkg::*;

typedef enum logic [2:0] {
    PH_WAIT_CR,
    PH_AFTER_CR,
    PH_AFTER_A,
    PH_COLLECT,
    PH_ISSUED
} frame_phase_t;

typedef struct packed {
    logic [7:0] ch;
    logic       empty;
    logic       rep;
    logic       last;
} cmd_char_t;

// tracks the framing state and holds the command characters still to come out
class at_frame_tracker;
    frame_phase_t phase;
    logic         busy;
    logic [7:0]   store [MAX_COMMAND_CHARS];
    logic [3:0]   length;
    cmd_char_t    due [$];
    int           mismatches;

    function new();
        phase      = PH_WAIT_CR;
        busy       = 1'b0;
        length     = '0;
        mismatches = 0;
        foreach (store[i])
            store[i] = '0;
    endfunction

    function void issue_command(logic rep);
        cmd_char_t item;
        int        k;
        if (length == 0)
        begin
            item = '{ch: 8'h00, empty: 1'b1, rep: rep, last: 1'b1};
            due.push_back(item);
        end
        else
        begin
            for (k = 0; k < length; k++)
            begin
                item = '{ch: store[k], empty: 1'b0, rep: rep, last: (k == length - 1)};
                due.push_back(item);
            end
        end
    endfunction

    // returns 0 when the block swallows a byte while it waits for done
    function bit take_request(logic op, logic [7:0] b);
        if (op == OP_DONE)
        begin
            busy = 1'b0;
            return 1'b1;
        end
        if (phase == PH_ISSUED)
        begin
            if (busy)
                return 1'b0;
            phase = PH_AFTER_CR;
        end
        case (phase)
            PH_AFTER_CR:
                if (b == CHAR_A_UP || b == CHAR_A_LO)
                    phase = PH_AFTER_A;
                else if (b != CHAR_LF)
                    phase = PH_WAIT_CR;
            PH_AFTER_A:
                if (b == CHAR_T_UP || b == CHAR_T_LO)
                begin
                    phase  = PH_COLLECT;
                    length = '0;
                end
                else if (b == CHAR_SLASH)
                begin
                    busy  = 1'b1;
                    phase = PH_ISSUED;
                    issue_command(1'b1);
                end
                else
                    phase = PH_WAIT_CR;
            PH_COLLECT:
                if (b == CHAR_CR)
                begin
                    busy  = 1'b1;
                    phase = PH_ISSUED;
                    issue_command(1'b0);
                end
                else if (length < MAX_COMMAND_CHARS)
                begin
                    store[length] = b;
                    length++;
                end
            default:
                phase = (b == CHAR_CR) ? PH_AFTER_CR : PH_WAIT_CR;
        endcase
        return 1'b1;
    endfunction

    function void match_item(cmd_char_t got);
        cmd_char_t want;
        if (due.size() == 0)
        begin
            $error("command item with none pending: cmd_byte %02h", got.ch);
            mismatches++;
            return;
        end
        want = due.pop_front();
        if (got.ch !== want.ch)
        begin
            $error("cmd_byte: expected %02h, got %02h", want.ch, got.ch);
            mismatches++;
        end
        if (got.empty !== want.empty)
        begin
            $error("cmd_empty: expected %0b, got %0b", want.empty, got.empty);
            mismatches++;
        end
        if (got.rep !== want.rep)
        begin
            $error("is_repeat: expected %0b, got %0b", want.rep, got.rep);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
        end
    endfunction
endclass

module tb;
    // idle cycles without any handshake before the run is declared hung
    localparam int IDLE_LIMIT   = 3000;
    // length of the one long hold-off on the command side
    localparam int HOLD_CYCLES  = 400;
    // requests the block acts on in the random part
    localparam int RANDOM_ITEMS = 140;

    logic clk;
    logic rst_n;

    atcr_in_if  rx_ch ();
    atcr_out_if cmd_ch ();

    at_frame_tracker tracker;

    bit calm;      // no idling on either side for the current sequence
    bit hold_now;  // asks the command side for its long hold-off
    int counted;   // requests the block acted on

    at_command_receiver_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .cmd   (cmd_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly back to back, sometimes a short gap, now and then a long gap
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request, wait for the handshake, then maybe drop valid for a gap
    task automatic send_request(logic op, logic [7:0] b);
        int gap;
        rx_ch.valid   <= 1'b1;
        rx_ch.opcode  <= op;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        counted += tracker.take_request(op, b);
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        send_request(OP_BYTE, b);
    endtask

    task automatic send_done();
        send_request(OP_DONE, 8'($urandom_range(0, 255)));
    endtask

    // carriage return (usually), up to two line feeds, then A in either case
    task automatic lead_in();
        if ($urandom_range(0, 3) != 0)
            send_byte(CHAR_CR);
        repeat ($urandom_range(0, 2))
            send_byte(CHAR_LF);
        send_byte($urandom_range(0, 1) ? CHAR_A_UP : CHAR_A_LO);
    endtask

    // sometimes a stray byte while busy, then usually the done request
    task automatic close_command();
        if ($urandom_range(0, 9) < 3)
            send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) != 0)
            send_done();
    endtask

    // command characters: any byte, though a carriage return is kept rare
    function automatic logic [7:0] pick_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_CR && $urandom_range(0, 3) != 0)
            b = 8'h20;
        return b;
    endfunction

    // stimulus side
    initial
    begin
        int  len;
        int  kind;
        int  i;
        bit  held;
        tracker        = new();
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.opcode   = OP_BYTE;
        rx_ch.rx_byte  = 8'h00;
        cmd_ch.ready   = 1'b0;
        calm           = 1'b0;
        hold_now       = 1'b0;
        held           = 1'b0;
        counted        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_request(OP_DONE, 8'hFF);   // done while idle does nothing
        send_byte(CHAR_CR);
        send_byte(CHAR_A_LO);
        send_byte(CHAR_SLASH);          // repeat with nothing stored: one empty item
        send_byte(8'h78);               // byte while busy is dropped
        send_request(OP_DONE, 8'h00);
        send_byte(CHAR_LF);             // after done a line feed keeps waiting for A
        send_byte(CHAR_A_UP);
        send_byte(CHAR_T_LO);
        send_request(OP_DONE, 8'h5A);   // done while collecting leaves the phase alone
        send_byte(8'h00);
        send_byte(8'hFF);
        for (i = 0; i < 14; i++)
            send_byte(8'h30 + 8'(i));   // sixteen characters: the last one is dropped
        send_byte(CHAR_CR);
        send_done();
        send_byte(CHAR_A_UP);           // AT straight after done
        send_byte(CHAR_T_UP);
        send_byte(CHAR_CR);             // nothing after AT: empty item
        send_done();
        send_byte(8'h51);               // anything else goes back to waiting for CR

        // random part
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 99);
            // once, around the middle: a full length command while the command
            // side holds off, so the block backs up into the request side
            if (!held && counted > RANDOM_ITEMS / 2)
            begin
                held     = 1'b1;
                calm     = 1'b1;
                hold_now = 1'b1;
                kind     = 0;
            end
            if (kind < 60)
            begin
                if (hold_now)
                    len = MAX_COMMAND_CHARS;
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(MAX_COMMAND_CHARS + 1, MAX_COMMAND_CHARS + 5);
                else
                    len = $urandom_range(0, MAX_COMMAND_CHARS);
                lead_in();
                send_byte($urandom_range(0, 1) ? CHAR_T_UP : CHAR_T_LO);
                repeat (len)
                    send_byte(pick_char());
                send_byte(CHAR_CR);
                close_command();
            end
            else if (kind < 75)
            begin
                lead_in();
                send_byte(CHAR_SLASH);
                close_command();
            end
            else if (kind < 90)
            begin
                // broken framing: a random byte where the sequence expects more
                if ($urandom_range(0, 1))
                    lead_in();
                else
                    send_byte(CHAR_CR);
                send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_done();
                    else
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        rx_ch.valid <= 1'b0;
        calm = 1'b0;

        // drain, then give the block a little time to show anything extra
        while (tracker.due.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.due.size() == 0)
            $display("** at_command_receiver_top: PASSED **");
        else
            $display("** at_command_receiver_top: FAILED **");
        $finish;
    end

    // command side: check every accepted item, stall at random
    initial
    begin : result_side
        int        stall_left;
        int        r;
        cmd_char_t seen;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen.ch    = cmd_ch.cmd_byte;
                seen.empty = cmd_ch.cmd_empty;
                seen.rep   = cmd_ch.is_repeat;
                seen.last  = cmd_ch.last;
                tracker.match_item(seen);
            end
            if (hold_now)
            begin
                hold_now   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm)
            begin
                r = $urandom_range(0, 99);
                if (r >= 92)
                    stall_left = $urandom_range(8, 40);
                else if (r >= 70)
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                cmd_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                cmd_ch.ready <= 1'b1;
        end
    end

    // watchdog: too long without any handshake on either side means a hang
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** at_command_receiver_top: FAILED **");
        $finish;
    end
endmodule
